FILE: rtl/assert_macros.svh
// Assertion macros shared by the formatter RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define CHK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication check
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

FILE: rtl/itoa_pkg.sv
// Types, codes and character constants for the integer-to-ASCII formatter.
// No dependencies; used by itoa_digits and integer_to_ascii_formatter.
package itoa_pkg;

	localparam int VALUE_W      = 32;
	localparam int NUM_DIGITS   = 10;
	localparam int RESULT_LIMIT = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_UDEC = 2'd0,
		KIND_HEX  = 2'd1,
		KIND_SDEC = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_SIGN,
		ST_PAD,
		ST_DIGIT
	} state_t;

	// Request to the digit unit
	typedef struct packed {
		logic start;
		logic hex;
	} conv_ctrl_t;

	// Map one digit (0..15) to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10)
			return CHAR_ZERO + {4'b0, d};
		else
			return CHAR_UPPER + {4'b0, d} - 8'd10;
	endfunction

endpackage

FILE: rtl/itoa_if.sv
// Valid/ready channel interfaces for formatter requests and characters.
// Standalone; no package dependency.
interface itoa_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] value;
	logic [5:0]  field_width;
	logic        zero_pad;

	modport source(output valid, kind, value, field_width, zero_pad, input ready);
	modport sink(input valid, kind, value, field_width, zero_pad, output ready);
endinterface

interface itoa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source(output valid, character, last, input ready);
	modport sink(input valid, character, last, output ready);
endinterface

FILE: rtl/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter: one request (kind, value, field width, zero pad) in,
// a stream of ASCII characters out, most significant digit first, last marked.
// Flow: decimal requests pass through the bit-serial BCD converter
// (32 shift steps, one bit per cycle, then the done flag), hex requests load
// directly; a sizing state follows, then one character per cycle while the
// sink is ready, then a return to idle to take the next request. A request
// yields at most 32 characters. One request is in flight at a time; a
// request of kind 3 is accepted and yields no characters.
`include "assert_macros.svh"

module integer_to_ascii_formatter import itoa_pkg::*; #(
	parameter int MAX_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	itoa_in_if.sink       din,
	itoa_out_if.source    dout
);

	localparam int LIMIT = (MAX_WIDTH < RESULT_LIMIT) ? MAX_WIDTH : RESULT_LIMIT;
	localparam int FILL_W = $clog2(RESULT_LIMIT + 1);
	localparam logic [FILL_W-1:0] LIMIT_W = FILL_W'(LIMIT);
	localparam int IDX_W = $clog2(NUM_DIGITS);

	state_t                     state_q, state_d;
	conv_ctrl_t                 ctrl;
	logic                       conv_done;
	logic [NUM_DIGITS-1:0][3:0] digits;
	logic [VALUE_W-1:0]         mag;

	logic                       neg_q;
	logic [7:0]                 pad_char_q;
	logic [FILL_W-1:0]          width_q;
	logic [FILL_W-1:0]          fill_q;
	logic [IDX_W-1:0]           idx_q;

	logic                       out_valid_q;
	logic [7:0]                 out_char_q;
	logic                       out_last_q;

	logic                       adv;
	logic                       emit;
	logic [7:0]                 emit_char;
	logic                       emit_last;
	logic [IDX_W-1:0]           msd;
	logic [FILL_W-1:0]          len;
	logic [FILL_W-1:0]          fill_calc;

	logic                       req_take;
	logic                       last_seen;

	// Magnitude of the incoming value
	assign mag = (din.kind == KIND_SDEC && din.value[VALUE_W-1]) ? (~din.value + 1'b1)
		: din.value;

	itoa_digits u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.bin    (mag),
		.done   (conv_done),
		.digits (digits)
	);

	// Size the number: most significant nonzero digit and fill count
	always_comb begin
		msd = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (digits[i] != 4'd0)
				msd = IDX_W'(i);
		end
		len       = FILL_W'(msd) + 1'b1;
		fill_calc = (width_q > len) ? width_q - len : '0;
	end

	assign adv = !out_valid_q || dout.ready;
	assign din.ready = (state_q == ST_IDLE);

	// Next state and character selection
	always_comb begin
		state_d    = state_q;
		ctrl.start = 1'b0;
		ctrl.hex   = 1'b0;
		emit       = 1'b0;
		emit_char  = CHAR_ZERO;
		emit_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (din.valid && din.kind != KIND_NONE) begin
					ctrl.start = 1'b1;
					ctrl.hex   = (din.kind == KIND_HEX);
					state_d    = ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done)
					state_d = ST_SIZE;
			end
			ST_SIZE: begin
				if (neg_q)
					state_d = ST_SIGN;
				else if (fill_calc != '0)
					state_d = ST_PAD;
				else
					state_d = ST_DIGIT;
			end
			ST_SIGN: begin
				if (adv) begin
					emit      = 1'b1;
					emit_char = CHAR_MINUS;
					state_d   = ST_DIGIT;
				end
			end
			ST_PAD: begin
				if (adv) begin
					emit      = 1'b1;
					emit_char = pad_char_q;
					if (fill_q == FILL_W'(1))
						state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (adv) begin
					emit      = 1'b1;
					emit_char = digit_char(digits[idx_q]);
					emit_last = (idx_q == '0);
					if (idx_q == '0)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Capture request options; load and step the fill and digit counters
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			neg_q      <= (din.kind == KIND_SDEC) && din.value[VALUE_W-1];
			pad_char_q <= din.zero_pad ? CHAR_ZERO : CHAR_SPACE;
			if (din.kind == KIND_SDEC)
				width_q <= '0;
			else if (FILL_W'(din.field_width) > LIMIT_W)
				width_q <= LIMIT_W;
			else
				width_q <= FILL_W'(din.field_width);
		end
		if (state_q == ST_SIZE) begin
			fill_q <= fill_calc;
			idx_q  <= msd;
		end else if (emit && state_q == ST_PAD) begin
			fill_q <= fill_q - 1'b1;
		end else if (emit && state_q == ST_DIGIT) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// Output register: load a character, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.character = out_char_q;
	assign dout.last      = out_last_q;

	assign req_take  = din.valid && din.ready && din.kind != KIND_NONE;
	assign last_seen = out_valid_q && out_last_q;

	`CHK_IMP(a_pad_has_fill, state_q == ST_PAD, fill_q != '0)
	`CHK_IMP(a_digit_idx_range, state_q == ST_DIGIT, idx_q < IDX_W'(NUM_DIGITS))
	`CHK_NEXT(a_accept_starts_conv, req_take, state_q == ST_CONV)
	`CHK_IMP(a_last_is_digit, last_seen, out_char_q != CHAR_SPACE && out_char_q != CHAR_MINUS)

endmodule

FILE: rtl/itoa_digits.sv
// Digit unit: bit-serial binary-to-BCD (shift and add-3) or direct hex load.
// Depends on itoa_pkg.
module itoa_digits import itoa_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  conv_ctrl_t                  ctrl,
	input  logic [VALUE_W-1:0]          bin,
	output logic                        done,
	output logic [NUM_DIGITS-1:0][3:0]  digits
);

	localparam int CNT_W = $clog2(VALUE_W);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [VALUE_W-1:0]         bin_q;
	logic [NUM_DIGITS-1:0][3:0] bcd_q;
	logic [NUM_DIGITS-1:0][3:0] bcd_adj;
	logic [NUM_DIGITS*4-1:0]    adj_flat;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign adj_flat = bcd_adj;

	// Control: run VALUE_W shift steps per decimal request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= !ctrl.hex;
				done_q <= ctrl.hex;
				cnt_q  <= CNT_W'(VALUE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load, then shift one binary bit into the BCD word per cycle
	// (the bit shifted out of the top digit is always zero)
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			bin_q <= bin;
			if (ctrl.hex)
				bcd_q <= {{(NUM_DIGITS * 4 - VALUE_W){1'b0}}, bin};
			else
				bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj_flat[NUM_DIGITS*4-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule
